### hw/rtl/oven_mode_sequencer_macros.svh
// assertion macros used by the checker file
`ifndef OVEN_MODE_SEQUENCER_MACROS_SVH
`define OVEN_MODE_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define OSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define OSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/osq_pkg.sv
// types, codes and reset values for the oven mode sequencer
`default_nettype none
package osq_pkg;

  typedef enum logic [2:0] {
    MODE_FAULT = 3'd0,
    MODE_IDLE  = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_DONE  = 3'd3,
    MODE_PAUSE = 3'd4,
    MODE_HAND  = 3'd5
  } osq_mode_t;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RED   = 2'd1;
  localparam logic [1:0] OP_GREEN = 2'd2;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_OPEN      = 2'd1;
  localparam logic [1:0] FAULT_SHORT_GND = 2'd2;
  localparam logic [1:0] FAULT_SHORT_VCC = 2'd3;

  localparam logic [15:0] RAW_OPEN      = 16'hFFFF;
  localparam logic [15:0] RAW_SHORT_GND = 16'hFFFE;
  localparam logic [15:0] RAW_SHORT_VCC = 16'hFFFD;

  localparam logic [2:0] REG_PROFILE_COUNT    = 3'd0;
  localparam logic [2:0] REG_MANUAL_START     = 3'd1;
  localparam logic [2:0] REG_MANUAL_INCREMENT = 3'd2;
  localparam logic [2:0] REG_MANUAL_CEILING   = 3'd3;
  localparam logic [2:0] REG_MANUAL_FLOOR     = 3'd4;

  localparam logic [2:0]  RST_PROFILE_COUNT    = 3'd3;
  localparam logic [11:0] RST_MANUAL_START     = 12'd600;
  localparam logic [7:0]  RST_MANUAL_INCREMENT = 8'd20;
  localparam logic [11:0] RST_MANUAL_CEILING   = 12'd1000;
  localparam logic [11:0] RST_MANUAL_FLOOR     = 12'd200;

  typedef struct packed {
    logic [2:0]  profile_count;
    logic [11:0] manual_start;
    logic [7:0]  manual_increment;
    logic [11:0] manual_ceiling;
    logic [11:0] manual_floor;
  } osq_cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        temp_raw;
    logic signed [15:0] profile_target;
    logic               profile_done;
  } osq_item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] active_target;
    logic [1:0]         fault_code;
    logic [2:0]         selected_profile;
    logic               manual_selected;
    logic [11:0]        pending_manual;
    logic               manual_pending_flag;
    logic [15:0]        elapsed_ticks;
    logic               run_finished;
    logic               profile_reload;
    logic [2:0]         reload_index;
    logic               blink_led;
  } osq_result_t;

endpackage
`default_nettype wire

### hw/rtl/osq_cfg_regs.sv
// configuration register file behind the apb-style port
`default_nettype none
module osq_cfg_regs
  import osq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output osq_cfg_t         cfg
);

  osq_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.profile_count    <= RST_PROFILE_COUNT;
      cfg_r.manual_start     <= RST_MANUAL_START;
      cfg_r.manual_increment <= RST_MANUAL_INCREMENT;
      cfg_r.manual_ceiling   <= RST_MANUAL_CEILING;
      cfg_r.manual_floor     <= RST_MANUAL_FLOOR;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROFILE_COUNT:    cfg_r.profile_count    <= pwdata[2:0];
        REG_MANUAL_START:     cfg_r.manual_start     <= pwdata[11:0];
        REG_MANUAL_INCREMENT: cfg_r.manual_increment <= pwdata[7:0];
        REG_MANUAL_CEILING:   cfg_r.manual_ceiling   <= pwdata[11:0];
        REG_MANUAL_FLOOR:     cfg_r.manual_floor     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROFILE_COUNT:    prdata = {29'd0, cfg_r.profile_count};
      REG_MANUAL_START:     prdata = {20'd0, cfg_r.manual_start};
      REG_MANUAL_INCREMENT: prdata = {24'd0, cfg_r.manual_increment};
      REG_MANUAL_CEILING:   prdata = {20'd0, cfg_r.manual_ceiling};
      REG_MANUAL_FLOOR:     prdata = {20'd0, cfg_r.manual_floor};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/osq_in_stage.sv
// input register stage for event words
`default_nettype none
module osq_in_stage
  import osq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  osq_item_t      in_item,
  input  wire logic      drain,
  output logic           fire,
  output osq_item_t      item
);

  logic      valid_r;
  osq_item_t item_r;

  assign in_ready = !valid_r || drain;
  assign fire     = valid_r && drain;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/osq_core.sv
// mode state registers and the per-event next state logic
`default_nettype none
module osq_core
  import osq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   fire,
  input  osq_item_t   item,
  input  osq_cfg_t    cfg,
  output osq_result_t result
);

  osq_mode_t          mode_r, mode_nxt;
  logic signed [15:0] target_r, target_nxt;
  logic [1:0]         fault_r, fault_nxt;
  logic [2:0]         sel_r, sel_nxt;
  logic               mflag_r, mflag_nxt;
  logic [11:0]        mvalue_r, mvalue_nxt;
  logic               mchanged_r, mchanged_nxt;
  logic [15:0]        ticks_r, ticks_nxt;
  logic               blink_r, blink_nxt;
  logic               finished;
  logic               reload;
  logic [2:0]         ridx;
  logic [3:0]         sel_inc;
  logic [12:0]        msum;
  logic               raw_err;
  logic signed [15:0] mvalue_ext;

  assign raw_err    = item.temp_raw >= RAW_SHORT_VCC;
  assign mvalue_ext = signed'({4'd0, mvalue_r});

  always_comb begin
    mode_nxt     = mode_r;
    target_nxt   = target_r;
    fault_nxt    = fault_r;
    sel_nxt      = sel_r;
    mflag_nxt    = mflag_r;
    mvalue_nxt   = mvalue_r;
    mchanged_nxt = mchanged_r;
    ticks_nxt    = ticks_r;
    blink_nxt    = blink_r;
    finished     = 1'b0;
    reload       = 1'b0;
    ridx         = 3'd0;
    sel_inc      = {1'b0, sel_r} + 4'd1;
    msum         = {1'b0, mvalue_r} + {5'd0, cfg.manual_increment};

    case (item.opcode)
      OP_TICK: begin
        if (raw_err && mode_r != MODE_FAULT) begin
          mode_nxt  = MODE_FAULT;
          blink_nxt = 1'b1;
          if (item.temp_raw == RAW_OPEN) begin
            fault_nxt = FAULT_OPEN;
          end else if (item.temp_raw == RAW_SHORT_GND) begin
            fault_nxt = FAULT_SHORT_GND;
          end else begin
            fault_nxt = FAULT_SHORT_VCC;
          end
        end
        if (mode_nxt == MODE_RUN) begin
          target_nxt = item.profile_target;
          if (item.profile_done) begin
            mode_nxt = MODE_DONE;
            finished = 1'b1;
          end
        end
        ticks_nxt = ticks_r + 16'd1;
      end
      OP_RED: begin
        case (mode_r)
          MODE_FAULT, MODE_DONE, MODE_PAUSE: begin
            if (mode_r == MODE_FAULT) begin
              mflag_nxt = 1'b0;
            end
            reload     = 1'b1;
            blink_nxt  = 1'b0;
            target_nxt = 16'sd0;
            fault_nxt  = FAULT_NONE;
            mode_nxt   = MODE_IDLE;
          end
          MODE_IDLE: begin
            if (!mflag_r) begin
              mode_nxt = MODE_RUN;
            end else begin
              target_nxt = mvalue_ext;
              mode_nxt   = MODE_HAND;
            end
          end
          MODE_RUN: mode_nxt = MODE_PAUSE;
          MODE_HAND: begin
            if (mchanged_r) begin
              target_nxt   = mvalue_ext;
              mchanged_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_GREEN: begin
        case (mode_r)
          MODE_IDLE: begin
            if (sel_inc > {1'b0, cfg.profile_count}) begin
              sel_inc = 4'd0;
            end
            sel_nxt = sel_inc[2:0];
            if (sel_nxt < cfg.profile_count) begin
              mflag_nxt = 1'b0;
              reload    = 1'b1;
              ridx      = sel_nxt;
            end else begin
              mflag_nxt  = 1'b1;
              mvalue_nxt = cfg.manual_start;
            end
          end
          MODE_PAUSE: mode_nxt = MODE_RUN;
          MODE_HAND: begin
            if (msum > {1'b0, cfg.manual_ceiling}) begin
              mvalue_nxt = cfg.manual_floor;
            end else begin
              mvalue_nxt = msum[11:0];
            end
            mchanged_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (mode_nxt == MODE_DONE) begin
      target_nxt = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      target_r   <= 16'sd0;
      fault_r    <= FAULT_NONE;
      sel_r      <= 3'd0;
      mflag_r    <= 1'b0;
      mvalue_r   <= 12'd0;
      mchanged_r <= 1'b0;
      ticks_r    <= 16'd0;
      blink_r    <= 1'b0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      target_r   <= target_nxt;
      fault_r    <= fault_nxt;
      sel_r      <= sel_nxt;
      mflag_r    <= mflag_nxt;
      mvalue_r   <= mvalue_nxt;
      mchanged_r <= mchanged_nxt;
      ticks_r    <= ticks_nxt;
      blink_r    <= blink_nxt;
    end
  end

  always_comb begin
    result.mode                = mode_nxt;
    result.active_target       = target_nxt;
    result.fault_code          = fault_nxt;
    result.selected_profile    = sel_nxt;
    result.manual_selected     = mflag_nxt;
    result.pending_manual      = mvalue_nxt;
    result.manual_pending_flag = mchanged_nxt;
    result.elapsed_ticks       = ticks_nxt;
    result.run_finished        = finished;
    result.profile_reload      = reload;
    result.reload_index        = ridx;
    result.blink_led           = blink_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/osq_out_stage.sv
// result register stage toward the output channel
`default_nettype none
module osq_out_stage
  import osq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  osq_result_t result,
  output logic        space,
  output logic        out_valid,
  input  wire logic   out_ready,
  output osq_result_t out_result
);

  logic        valid_r;
  osq_result_t res_r;

  assign space      = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/oven_mode_sequencer.sv
// top level of the reflow oven mode sequencer
// a word in the input register passes through the mode logic into the result register once that register has space
// throughput: one word per cycle while out_tready is high, set by the single input and result register pair
// the mode logic between them is one pass of compares and a few small adds
// reset: synchronous active-low rst_n clears both stages, mode idle, registers to defaults
// no clearing pass; words are accepted as soon as reset is released
`default_nettype none
module oven_mode_sequencer
  import osq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // temp_raw[15:0], profile_target[31:16], profile_done[32], zero fill
  input  wire logic [39:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mode[2:0], active_target[18:3], fault_code[20:19], selected_profile[23:21],
  // manual_selected[24], pending_manual[36:25], manual_pending_flag[37],
  // elapsed_ticks[53:38], run_finished[54], profile_reload[55],
  // reload_index[58:56], blink_led[59], zero fill
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  osq_cfg_t    cfg;
  osq_item_t   in_item;
  osq_item_t   item;
  osq_result_t result;
  osq_result_t out_res;
  logic        fire;
  logic        space;

  assign cfg_pready = 1'b1;

  assign in_item.opcode         = in_tuser;
  assign in_item.temp_raw       = in_tdata[15:0];
  assign in_item.profile_target = signed'(in_tdata[31:16]);
  assign in_item.profile_done   = in_tdata[32];

  osq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  osq_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .drain    (space),
    .fire     (fire),
    .item     (item)
  );

  osq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  osq_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .space      (space),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_res)
  );

  assign out_tdata = {4'd0,
                      out_res.blink_led,
                      out_res.reload_index,
                      out_res.profile_reload,
                      out_res.run_finished,
                      out_res.elapsed_ticks,
                      out_res.manual_pending_flag,
                      out_res.pending_manual,
                      out_res.manual_selected,
                      out_res.selected_profile,
                      out_res.fault_code,
                      out_res.active_target,
                      out_res.mode};

endmodule
`default_nettype wire

### hw/rtl/osq_checker.sv
// port-level checks on the oven mode sequencer, bound to the top level
`default_nettype none
`include "oven_mode_sequencer_macros.svh"
module osq_checker
  import osq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  logic [2:0] mode_w;
  logic [1:0] fault_w;
  logic       blink_w;
  logic       reload_w;
  logic [2:0] ridx_w;
  logic       finished_w;
  logic [15:0] target_w;

  assign mode_w     = out_tdata[2:0];
  assign target_w   = out_tdata[18:3];
  assign fault_w    = out_tdata[20:19];
  assign finished_w = out_tdata[54];
  assign reload_w   = out_tdata[55];
  assign ridx_w     = out_tdata[58:56];
  assign blink_w    = out_tdata[59];

  // stalled result word holds
  `OSQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // fault code and blink track the fault mode
  `OSQ_ASSERT_NOW(a_fault_code, out_tvalid, (mode_w == MODE_FAULT) == (fault_w != FAULT_NONE), "fault code disagrees with mode")
  `OSQ_ASSERT_NOW(a_fault_blink, out_tvalid, (mode_w == MODE_FAULT) == blink_w, "blink disagrees with mode")

  // a finished run lands in done with zero target, reload index only with a reload
  `OSQ_ASSERT_NOW(a_finish_done, out_tvalid && finished_w, mode_w == MODE_DONE && target_w == 16'd0 && !reload_w && ridx_w == 3'd0, "run finish without done state")

endmodule

bind oven_mode_sequencer osq_checker u_osq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
